FILE: hw/rtl/bbc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and decode functions for the bracket balance checker.
// No dependencies; every other file of the block depends on this package.
package bbc_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [1:0]       kind_t;
    typedef logic [1:0]       status_t;
    typedef logic [7:0]       char_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // result codes
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_UNBALANCED = 2'd1;
    localparam status_t ST_EMPTY      = 2'd2;
    localparam status_t ST_OVERFLOW   = 2'd3;

    // error latch codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNBALANCED = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

    localparam char_t CH_END     = 8'h00;
    localparam char_t CH_OPEN_P  = 8'h28;  // (
    localparam char_t CH_OPEN_S  = 8'h5B;  // [
    localparam char_t CH_OPEN_C  = 8'h7B;  // {
    localparam char_t CH_OPEN_A  = 8'h3C;  // <
    localparam char_t CH_CLOSE_P = 8'h29;  // )
    localparam char_t CH_CLOSE_S = 8'h5D;  // ]
    localparam char_t CH_CLOSE_C = 8'h7D;  // }
    localparam char_t CH_CLOSE_A = 8'h3E;  // >

    localparam kind_t KIND_PAREN   = 2'd0;
    localparam kind_t KIND_SQUARE  = 2'd1;
    localparam kind_t KIND_CURLY   = 2'd2;
    localparam kind_t KIND_ANGLE   = 2'd3;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } bracket_t;

    // stack command from the control logic
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        kind_t kind;
    } stack_cmd_t;

    // stack state seen by the control logic
    typedef struct packed {
        count_t count;
        kind_t  top;
    } stack_view_t;

    function automatic bracket_t open_kind(input char_t ch);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (ch)
            CH_OPEN_P: b.kind = KIND_PAREN;
            CH_OPEN_S: b.kind = KIND_SQUARE;
            CH_OPEN_C: b.kind = KIND_CURLY;
            CH_OPEN_A: b.kind = KIND_ANGLE;
            default:   b.hit  = 1'b0;
        endcase
        return b;
    endfunction

    function automatic bracket_t close_kind(input char_t ch);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        case (ch)
            CH_CLOSE_P: b.kind = KIND_PAREN;
            CH_CLOSE_S: b.kind = KIND_SQUARE;
            CH_CLOSE_C: b.kind = KIND_CURLY;
            CH_CLOSE_A: b.kind = KIND_ANGLE;
            default:    b.hit  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/bbc_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the bracket balance checker.
// Depends on bbc_pkg for the payload types.
interface bbc_char_if;
    logic              valid;
    logic              ready;
    bbc_pkg::char_t    char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface bbc_status_if;
    logic              valid;
    logic              ready;
    bbc_pkg::status_t  status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

FILE: hw/rtl/bbc_stack.sv
`timescale 1ns / 1ps
// Bracket kind stack: top entry in a register, the rest in a synchronous RAM.
// Depends on bbc_pkg. The entry below the top is prefetched every cycle.
module bbc_stack
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbc_pkg::stack_cmd_t  cmd,
    output bbc_pkg::stack_view_t view
);
    import bbc_pkg::*;

    kind_t  mem [STACK_DEPTH];

    count_t cnt_reg, cnt_next;
    kind_t  top_reg, top_next;
    kind_t  rdata_reg;
    logic   byp_reg;
    kind_t  byp_data_reg;

    logic   we;
    count_t cnt_dec;
    count_t rd_pos;
    addr_t  waddr;
    addr_t  raddr;
    kind_t  below;

    assign below   = byp_reg ? byp_data_reg : rdata_reg;
    assign cnt_dec = cnt_reg - count_t'(1);
    assign waddr   = cnt_dec[ADDR_W-1:0];

    always_comb
    begin
        cnt_next = cnt_reg;
        top_next = top_reg;
        we       = 1'b0;
        if (cmd.clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.push)
        begin
            cnt_next = cnt_reg + count_t'(1);
            top_next = cmd.kind;
            // old top moves into RAM
            we       = (cnt_reg != '0);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_dec;
            top_next = below;
        end
    end

    // prefetch the entry that will sit below the next top
    assign rd_pos = cnt_next - count_t'(2);
    assign raddr  = rd_pos[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= top_reg;
        end
        rdata_reg    <= mem[raddr];
        byp_data_reg <= top_reg;
        top_reg      <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            byp_reg <= we && (waddr == raddr);
        end
    end

    assign view.count = cnt_reg;
    assign view.top   = top_reg;

endmodule

FILE: hw/rtl/bracket_balance_checker.sv
`timescale 1ns / 1ps
// Bracket balance checker, top level.
// Depends on bbc_pkg, bbc_channels and bbc_stack.
//
// Usage:
//   char_ch takes one text byte per beat; a zero byte ends the string.
//   status_ch gives one status beat per string end: 0 balanced, 1 unbalanced,
//   2 empty string, 3 stack overflow. Other bytes give no beat.
// Throughput: one byte per cycle while char_ch.ready is high. The top of stack lives in a
//   register and the entry below it is prefetched from the stack RAM every
//   cycle (registered read, write-to-read bypass), so pops and pushes may
//   follow each other in consecutive cycles.
// Output: the status for an end byte is registered in the output slot, or in the skid register if status_ch stalls.
// Stall: a status waiting on status_ch does not block input; a second status
//   goes to a skid register, and char_ch.ready drops only while that skid
//   register is occupied.
// Reset: rst_n clears the stack count, error latch and both output slots.
//   The stack RAM is not cleared; only entries pushed in the current string
//   are ever used. No clearing pass is needed.
module bracket_balance_checker
(
    input  logic                  clk,
    input  logic                  rst_n,
    bbc_char_if.sink              char_ch,
    bbc_status_if.source          status_ch
);
    import bbc_pkg::*;

    stack_cmd_t  cmd;
    stack_view_t view;

    logic       has_err;
    logic [1:0] err_code_reg, err_code_next;
    logic       seen_reg, seen_next;

    logic       out_valid_reg, out_valid_next;
    status_t    out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    status_t    skid_data_reg, skid_data_next;

    logic       accept;
    logic       is_end;
    logic       emit;
    status_t    result;
    bracket_t   ob, cb;
    logic       full, empty;

    bbc_stack u_stack
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .view  (view)
    );

    assign char_ch.ready = !skid_valid_reg;
    assign accept        = char_ch.valid && char_ch.ready;
    assign is_end        = (char_ch.char_code == CH_END);
    assign emit          = accept && is_end;
    assign ob            = open_kind(char_ch.char_code);
    assign cb            = close_kind(char_ch.char_code);
    assign full          = (view.count == count_t'(STACK_DEPTH));
    assign empty         = (view.count == '0);
    assign has_err       = (err_code_reg != ERR_NONE);

    always_comb
    begin
        cmd.push      = 1'b0;
        cmd.pop       = 1'b0;
        cmd.clear     = 1'b0;
        cmd.kind      = ob.kind;
        err_code_next = err_code_reg;
        seen_next     = seen_reg;
        if (accept)
        begin
            if (is_end)
            begin
                cmd.clear     = 1'b1;
                err_code_next = ERR_NONE;
                seen_next     = 1'b0;
            end
            else
            begin
                seen_next = 1'b1;
                if (!has_err)
                begin
                    if (ob.hit)
                    begin
                        if (full)
                        begin
                            err_code_next = ERR_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (cb.hit)
                    begin
                        if (empty)
                        begin
                            err_code_next = ERR_UNBALANCED;
                        end
                        else
                        begin
                            cmd.pop = 1'b1;
                            if (view.top != cb.kind)
                            begin
                                err_code_next = ERR_UNBALANCED;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (!seen_reg)
        begin
            result = ST_EMPTY;
        end
        else if (has_err)
        begin
            result = err_code_reg;
        end
        else if (!empty)
        begin
            result = ST_UNBALANCED;
        end
        else
        begin
            result = ST_OK;
        end
    end

    // output register plus skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || status_ch.ready)
        begin
            out_valid_next  = skid_valid_reg || emit;
            out_data_next   = skid_valid_reg ? skid_data_reg : result;
            skid_valid_next = 1'b0;
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_code_reg   <= ERR_NONE;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            err_code_reg   <= err_code_next;
            seen_reg       <= seen_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign status_ch.valid  = out_valid_reg;
    assign status_ch.status = out_data_reg;

endmodule
